[design/v110_ra1_frame_codec_macros.svh]
// Assertion macros shared by the codec's checking code.
`ifndef V110_RA1_FRAME_CODEC_MACROS_SVH
`define V110_RA1_FRAME_CODEC_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VRA1_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VRA1_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/vra1_pkg.sv]
// Types, constants and rate tables of the V.110 RA1 frame codec.
package vra1_pkg;

  localparam int unsigned FRAME_OCTETS = 10;
  localparam int unsigned D_BITS       = 48;
  localparam int unsigned MAP_COUNT    = 6;
  localparam logic [3:0]  RATE_COUNT   = 4'd12;
  localparam logic [3:0]  LAST_OCTET   = 4'd9;

  typedef enum logic {
    CMD_ENCODE  = 1'b0,
    CMD_RECEIVE = 1'b1
  } cmd_e;

  // D-bit mapping schemes; the repeat schemes come first, ordered by shift.
  typedef enum logic [2:0] {
    MAP_REP8   = 3'd0,
    MAP_REP4   = 3'd1,
    MAP_REP2   = 3'd2,
    MAP_DIRECT = 3'd3,
    MAP_FILL36 = 3'd4,
    MAP_FILL30 = 3'd5
  } map_e;

  // E1..E3 rate codes, E1 in bit 0.
  localparam logic [2:0] CODE_600     = 3'd1;
  localparam logic [2:0] CODE_1200    = 3'd2;
  localparam logic [2:0] CODE_2400    = 3'd3;
  localparam logic [2:0] CODE_N4800   = 3'd6;
  localparam logic [2:0] CODE_N3600   = 3'd5;
  localparam logic [2:0] CODE_N12000  = 3'd4;

  typedef struct packed {
    logic              decode;
    logic [9:0][7:0]   frame;
  } job_t;

  function automatic map_e rate_map(input logic [3:0] rate);
    map_e m;
    unique case (rate)
      4'd0:    m = MAP_REP8;
      4'd1:    m = MAP_REP4;
      4'd2:    m = MAP_REP2;
      4'd4,
      4'd7,
      4'd10:   m = MAP_FILL36;
      4'd6,
      4'd9:    m = MAP_FILL30;
      default: m = MAP_DIRECT;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] map_code(input map_e m);
    logic [2:0] c;
    unique case (m)
      MAP_REP8:   c = CODE_600;
      MAP_REP4:   c = CODE_1200;
      MAP_REP2:   c = CODE_2400;
      MAP_FILL36: c = CODE_N3600;
      MAP_FILL30: c = CODE_N12000;
      default:    c = CODE_N4800;
    endcase
    return c;
  endfunction

  function automatic logic [5:0] map_chunk(input map_e m);
    logic [5:0] n;
    unique case (m)
      MAP_REP8:   n = 6'd6;
      MAP_REP4:   n = 6'd12;
      MAP_REP2:   n = 6'd24;
      MAP_FILL36: n = 6'd36;
      MAP_FILL30: n = 6'd30;
      default:    n = 6'd48;
    endcase
    return n;
  endfunction

  // Data and fill run lengths of the two fill schemes.
  function automatic int run_data(input int tab, input int s);
    int n;
    if (tab == 0) begin
      unique case (s)
        0:       n = 10;
        3:       n = 14;
        6:       n = 4;
        7:       n = 0;
        default: n = 2;
      endcase
    end else begin
      unique case (s)
        0, 4:    n = 10;
        3, 7:    n = 1;
        default: n = 2;
      endcase
    end
    return n;
  endfunction

  function automatic int run_fill(input int tab, input int s);
    int n;
    if (tab == 0) begin
      n = (s >= 6) ? 0 : 2;
    end else begin
      n = (s == 3 || s == 7) ? 3 : 2;
    end
    return n;
  endfunction

  // User bit that feeds D bit p, or -1 where the D bit is a fill bit.
  function automatic int d_src(input int kind, input int p);
    int tab;
    int di;
    int ui;
    int res;
    res = -1;
    if (kind <= int'(MAP_DIRECT)) begin
      res = p >> (int'(MAP_DIRECT) - kind);
    end else begin
      tab = (kind == int'(MAP_FILL30)) ? 1 : 0;
      di  = 0;
      ui  = 0;
      for (int s = 0; s < 8; s++) begin
        for (int k = 0; k < run_data(tab, s); k++) begin
          if (di == p) res = ui;
          di++;
          ui++;
        end
        di += run_fill(tab, s);
      end
    end
    return res;
  endfunction

  // D bit that carries user bit i on receive (first copy), or -1 if unused.
  function automatic int u_src(input int kind, input int i);
    int tab;
    int di;
    int ui;
    int res;
    res = -1;
    if (kind <= int'(MAP_DIRECT)) begin
      if (i < (48 >> (int'(MAP_DIRECT) - kind))) res = i << (int'(MAP_DIRECT) - kind);
    end else begin
      tab = (kind == int'(MAP_FILL30)) ? 1 : 0;
      di  = 0;
      ui  = 0;
      for (int s = 0; s < 8; s++) begin
        for (int k = 0; k < run_data(tab, s); k++) begin
          if (ui == i) res = di;
          di++;
          ui++;
        end
        di += run_fill(tab, s);
      end
    end
    return res;
  endfunction

endpackage

[design/vra1_if.sv]
// Valid/ready channel interfaces for the codec's input and result items.
interface vra1_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [47:0] user_bits;
  logic [5:0]  s_bits;
  logic [1:0]  x_bits;
  logic [3:0]  e_upper;
  logic [7:0]  rx_octet;

  modport source (output valid, command, user_bits, s_bits, x_bits, e_upper, rx_octet,
                  input ready);
  modport sink   (input valid, command, user_bits, s_bits, x_bits, e_upper, rx_octet,
                  output ready);
endinterface

interface vra1_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tx_octet;
  logic [3:0]  octet_index;
  logic        last;
  logic [47:0] user_bits_out;
  logic [5:0]  user_count;
  logic [5:0]  s_bits_out;
  logic [1:0]  x_bits_out;
  logic [6:0]  e_bits_out;
  logic        status;

  modport source (output valid, tx_octet, octet_index, last, user_bits_out, user_count,
                  s_bits_out, x_bits_out, e_bits_out, status,
                  input ready);
  modport sink   (input valid, tx_octet, octet_index, last, user_bits_out, user_count,
                  s_bits_out, x_bits_out, e_bits_out, status,
                  output ready);
endinterface

[design/vra1_front.sv]
// Front end: accepts items, builds encoded frames and gathers received octets.
module vra1_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [3:0]        rate_i,
  vra1_in_if.sink           in_i,
  input  logic              full_i,
  output logic              push_o,
  output vra1_pkg::job_t    job_o
);

  logic [3:0]                 rx_cnt_q, rx_cnt_d;
  logic [7:0]                 store_q [0:8];
  logic                       accept;
  logic                       is_rx;
  logic                       rate_ok;
  vra1_pkg::map_e             map;
  logic [5:0][47:0]           d_cand;
  logic [47:0]                d;
  logic [9:0][7:0]            enc;

  assign in_i.ready = ~full_i;
  assign accept     = in_i.valid & in_i.ready;
  assign is_rx      = (in_i.command == vra1_pkg::CMD_RECEIVE);
  assign rate_ok    = (rate_i < vra1_pkg::RATE_COUNT);
  assign map        = vra1_pkg::rate_map(rate_i);

  // Each mapping scheme is a fixed wiring of user bits and fill bits.
  for (genvar k = 0; k < vra1_pkg::MAP_COUNT; k++) begin : g_map
    for (genvar p = 0; p < vra1_pkg::D_BITS; p++) begin : g_bit
      localparam int Src = vra1_pkg::d_src(k, p);
      if (Src < 0) begin : g_fill
        assign d_cand[k][p] = 1'b1;
      end else begin : g_data
        assign d_cand[k][p] = in_i.user_bits[Src];
      end
    end
  end

  always_comb begin
    unique case (map)
      vra1_pkg::MAP_REP8:   d = d_cand[0];
      vra1_pkg::MAP_REP4:   d = d_cand[1];
      vra1_pkg::MAP_REP2:   d = d_cand[2];
      vra1_pkg::MAP_FILL36: d = d_cand[4];
      vra1_pkg::MAP_FILL30: d = d_cand[5];
      default:              d = d_cand[3];
    endcase
  end

  always_comb begin
    enc = '0;
    for (int o = 1; o < 10; o++) begin
      enc[o][0] = 1'b1;
    end
    for (int g = 0; g < 8; g++) begin
      enc[(g < 4) ? g + 1 : g + 2][6:1] = d[6*g +: 6];
    end
    enc[1][7]   = in_i.s_bits[0];
    enc[2][7]   = in_i.x_bits[0];
    enc[3][7]   = in_i.s_bits[1];
    enc[4][7]   = in_i.s_bits[2];
    enc[6][7]   = in_i.s_bits[3];
    enc[7][7]   = in_i.x_bits[1];
    enc[8][7]   = in_i.s_bits[4];
    enc[9][7]   = in_i.s_bits[5];
    enc[5][7:1] = {in_i.e_upper, vra1_pkg::map_code(map)};
  end

  always_comb begin
    job_o.decode = is_rx;
    if (is_rx) begin
      for (int o = 0; o < 9; o++) begin
        job_o.frame[o] = store_q[o];
      end
      job_o.frame[9] = in_i.rx_octet;
    end else begin
      job_o.frame = enc;
    end
  end

  // A received octet only produces a job when it completes the frame.
  assign push_o = accept & (is_rx ? (rx_cnt_q == vra1_pkg::LAST_OCTET) : rate_ok);

  always_comb begin
    rx_cnt_d = rx_cnt_q;
    if (accept && is_rx) begin
      rx_cnt_d = (rx_cnt_q == vra1_pkg::LAST_OCTET) ? 4'd0 : rx_cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_cnt_q <= 4'd0;
    end else begin
      rx_cnt_q <= rx_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_rx && rx_cnt_q != vra1_pkg::LAST_OCTET) begin
      store_q[rx_cnt_q] <= in_i.rx_octet;
    end
  end

endmodule

[design/vra1_queue.sv]
// Small job queue that decouples the front end from the back end.
module vra1_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vra1_pkg::job_t    data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output vra1_pkg::job_t    data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  vra1_pkg::job_t    entries_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entries_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= data_i;
    end
  end

endmodule

[design/vra1_back.sv]
// Back end: streams encoded octets and decodes completed receive frames.
module vra1_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [3:0]        rate_i,
  input  logic              head_valid_i,
  input  vra1_pkg::job_t    head_i,
  output logic              pop_o,
  vra1_out_if.source        out_o
);

  logic [3:0]         cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         tx_q;
  logic [3:0]         idx_q;
  logic               last_q;
  logic [47:0]        user_q;
  logic [5:0]         count_q;
  logic [5:0]         s_q;
  logic [1:0]         x_q;
  logic [6:0]         e_q;
  logic               status_q;

  logic               load;
  logic               enc_last;
  vra1_pkg::map_e     map;
  logic [47:0]        dec_d;
  logic [5:0][47:0]   u_cand;
  logic [47:0]        dec_u;
  logic [5:0]         dec_s;
  logic [1:0]         dec_x;
  logic [6:0]         dec_e;
  logic               dec_ok;

  assign map = vra1_pkg::rate_map(rate_i);

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      dec_d[6*g +: 6] = head_i.frame[(g < 4) ? g + 1 : g + 2][6:1];
    end
  end

  // Only the first copy of a repeated bit is read back.
  for (genvar k = 0; k < vra1_pkg::MAP_COUNT; k++) begin : g_map
    for (genvar i = 0; i < vra1_pkg::D_BITS; i++) begin : g_bit
      localparam int Src = vra1_pkg::u_src(k, i);
      if (Src < 0) begin : g_none
        assign u_cand[k][i] = 1'b0;
      end else begin : g_data
        assign u_cand[k][i] = dec_d[Src];
      end
    end
  end

  always_comb begin
    unique case (map)
      vra1_pkg::MAP_REP8:   dec_u = u_cand[0];
      vra1_pkg::MAP_REP4:   dec_u = u_cand[1];
      vra1_pkg::MAP_REP2:   dec_u = u_cand[2];
      vra1_pkg::MAP_FILL36: dec_u = u_cand[4];
      vra1_pkg::MAP_FILL30: dec_u = u_cand[5];
      default:              dec_u = u_cand[3];
    endcase
  end

  assign dec_s  = {head_i.frame[9][7], head_i.frame[8][7], head_i.frame[6][7],
                   head_i.frame[4][7], head_i.frame[3][7], head_i.frame[1][7]};
  assign dec_x  = {head_i.frame[7][7], head_i.frame[2][7]};
  assign dec_e  = head_i.frame[5][7:1];
  assign dec_ok = (rate_i < vra1_pkg::RATE_COUNT) &&
                  (dec_e[2:0] == vra1_pkg::map_code(map));

  // The result register refills in the same cycle that its content is taken.
  assign load     = head_valid_i & (~out_valid_q | out_o.ready);
  assign enc_last = (cnt_q == vra1_pkg::LAST_OCTET);
  assign pop_o    = load & (head_i.decode | enc_last);

  always_comb begin
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load && !head_i.decode) begin
      cnt_d = enc_last ? 4'd0 : cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= 4'd0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (head_i.decode) begin
        tx_q     <= 8'd0;
        idx_q    <= vra1_pkg::LAST_OCTET;
        last_q   <= 1'b1;
        user_q   <= dec_ok ? dec_u : 48'd0;
        count_q  <= dec_ok ? vra1_pkg::map_chunk(map) : 6'd0;
        s_q      <= dec_s;
        x_q      <= dec_x;
        e_q      <= dec_e;
        status_q <= ~dec_ok;
      end else begin
        tx_q     <= head_i.frame[cnt_q];
        idx_q    <= cnt_q;
        last_q   <= enc_last;
        user_q   <= 48'd0;
        count_q  <= 6'd0;
        s_q      <= 6'd0;
        x_q      <= 2'd0;
        e_q      <= 7'd0;
        status_q <= 1'b0;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.tx_octet      = tx_q;
  assign out_o.octet_index   = idx_q;
  assign out_o.last          = last_q;
  assign out_o.user_bits_out = user_q;
  assign out_o.user_count    = count_q;
  assign out_o.s_bits_out    = s_q;
  assign out_o.x_bits_out    = x_q;
  assign out_o.e_bits_out    = e_q;
  assign out_o.status        = status_q;

endmodule

[design/v110_ra1_frame_codec.sv]
// Top level of the V.110 RA1 frame codec.
// An encode command at a rate in use turns one user chunk into a V.110 frame and delivers
// its ten octets on the result channel, one per cycle while the channel is ready, stepped
// through by the octet counter in the back end; an encode at an unused rate is dropped.
// A receive command takes one octet per cycle while the job queue (QueueDepth entries, two
// or more) is not full; every tenth octet completes a frame, which is decoded and delivered
// as one result. The front end keeps accepting while the back end streams, held back only
// when the queue is full. The rate register is to be written only while the codec is idle.
`include "v110_ra1_frame_codec_macros.svh"

module v110_ra1_frame_codec #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  vra1_in_if.sink     in_i,
  vra1_out_if.source  out_o
);

  logic [3:0]         rate_q;
  logic               push;
  logic               full;
  logic               pop;
  logic               empty;
  vra1_pkg::job_t     push_job;
  vra1_pkg::job_t     head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= 4'd0;
    end else if (cfg_we_i) begin
      rate_q <= cfg_wdata_i;
    end
  end

  vra1_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rate_i (rate_q),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  vra1_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_job)
  );

  vra1_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rate_i       (rate_q),
    .head_valid_i (~empty),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_o        (out_o)
  );

  `VRA1_ASSERT_SAME(a_no_push_when_full, push, !full, "job pushed into a full queue")
  `VRA1_ASSERT_SAME(a_no_pop_when_empty, pop, !empty, "job popped from an empty queue")
  `VRA1_ASSERT_NEXT(a_frame_continues, out_o.valid && out_o.ready && !out_o.last, out_o.valid, "encoded frame broke off before its last octet")
  `VRA1_ASSERT_SAME(a_error_no_user, out_o.valid && out_o.status, out_o.user_count == 6'd0 && out_o.user_bits_out == 48'd0, "user bits delivered with a rate code mismatch")

endmodule

[tb/tb_v110_ra1_frame_codec.sv]
// Self-checking testbench for the V.110 RA1 frame codec: random traffic against a rate-aware predictor.
`timescale 1ns / 1ps

module tb_v110_ra1_frame_codec;

  // User rates as written to the rate register.
  localparam logic [3:0] RATE_600      = 4'd0;
  localparam logic [3:0] RATE_1200     = 4'd1;
  localparam logic [3:0] RATE_2400     = 4'd2;
  localparam logic [3:0] RATE_4800     = 4'd3;
  localparam logic [3:0] RATE_7200     = 4'd4;
  localparam logic [3:0] RATE_9600     = 4'd5;
  localparam logic [3:0] RATE_12000    = 4'd6;
  localparam logic [3:0] RATE_14400    = 4'd7;
  localparam logic [3:0] RATE_19200    = 4'd8;
  localparam logic [3:0] RATE_24000    = 4'd9;
  localparam logic [3:0] RATE_28800    = 4'd10;
  localparam logic [3:0] RATE_38400    = 4'd11;
  localparam logic [3:0] RATE_SPARE_LO = 4'd12;
  localparam logic [3:0] RATE_SPARE_HI = 4'd15;
  localparam logic [3:0] RATES_IN_USE  = 4'd12;

  // E1..E3 codes, E1 in bit 0.
  localparam logic [2:0] ECODE_600    = 3'b001;
  localparam logic [2:0] ECODE_1200   = 3'b010;
  localparam logic [2:0] ECODE_2400   = 3'b011;
  localparam logic [2:0] ECODE_N4800  = 3'b110;
  localparam logic [2:0] ECODE_N3600  = 3'b101;
  localparam logic [2:0] ECODE_N12000 = 3'b100;

  // Data and fill run lengths, run 0 in the lowest nibble.
  localparam logic [7:0][3:0] RUN_DATA_3600  = {4'd0, 4'd4, 4'd2, 4'd2, 4'd14, 4'd2, 4'd2, 4'd10};
  localparam logic [7:0][3:0] RUN_FILL_3600  = {4'd0, 4'd0, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2};
  localparam logic [7:0][3:0] RUN_DATA_12000 = {4'd1, 4'd2, 4'd2, 4'd10, 4'd1, 4'd2, 4'd2, 4'd10};
  localparam logic [7:0][3:0] RUN_FILL_12000 = {4'd3, 4'd2, 4'd2, 4'd2, 4'd3, 4'd2, 4'd2, 4'd2};

  localparam int PHASES          = 17;
  localparam int ITEMS_PER_PHASE = 20;
  localparam int SETTLE_CYCLES   = 30;
  localparam int PRINT_LIMIT     = 50;

  typedef struct packed {
    vra1_pkg::cmd_e command;
    logic [47:0]    user_bits;
    logic [5:0]     s_bits;
    logic [1:0]     x_bits;
    logic [3:0]     e_upper;
    logic [7:0]     rx_octet;
  } codec_item_t;

  typedef struct packed {
    logic [7:0]  tx_octet;
    logic [3:0]  octet_index;
    logic        last;
    logic [47:0] user_bits_out;
    logic [5:0]  user_count;
    logic [5:0]  s_bits_out;
    logic [1:0]  x_bits_out;
    logic [6:0]  e_bits_out;
    logic        status;
  } ra1_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we    = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;

  vra1_in_if  codec_in ();
  vra1_out_if codec_out ();

  v110_ra1_frame_codec i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (codec_in),
    .out_o       (codec_out)
  );

  codec_item_t codec_jobs[$];
  ra1_result_t ra1_results_due[$];

  // Predictor state.
  logic [3:0]      model_rate = RATE_600;
  int              rx_count   = 0;
  logic [9:0][7:0] rx_store;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int items_made     = 0;
  int gen_rx_phase   = 0;

  logic [3:0] phase_rate [PHASES] = '{
    RATE_600, RATE_38400, RATE_2400, RATE_4800, RATE_1200, RATE_7200, RATE_9600,
    RATE_12000, RATE_14400, RATE_19200, RATE_24000, RATE_28800, RATE_SPARE_LO,
    RATE_2400, RATE_SPARE_HI, RATE_600, RATE_38400
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni             = 1'b0;
    codec_in.valid     = 1'b0;
    codec_in.command   = vra1_pkg::CMD_ENCODE;
    codec_in.user_bits = '0;
    codec_in.s_bits    = '0;
    codec_in.x_bits    = '0;
    codec_in.e_upper   = '0;
    codec_in.rx_octet  = '0;
    codec_out.ready    = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic logic [47:0] rnd48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic int repeat_factor(input logic [3:0] r);
    case (r)
      RATE_600:  return 8;
      RATE_1200: return 4;
      RATE_2400: return 2;
      RATE_4800, RATE_9600, RATE_19200, RATE_38400: return 1;
      default:   return 0;
    endcase
  endfunction

  function automatic logic [2:0] ecode_of(input logic [3:0] r);
    case (r)
      RATE_600:  return ECODE_600;
      RATE_1200: return ECODE_1200;
      RATE_2400: return ECODE_2400;
      RATE_7200, RATE_14400, RATE_28800: return ECODE_N3600;
      RATE_12000, RATE_24000: return ECODE_N12000;
      default:   return ECODE_N4800;
    endcase
  endfunction

  function automatic logic [5:0] chunk_of(input logic [3:0] r);
    case (r)
      RATE_7200, RATE_14400, RATE_28800: return 6'd36;
      RATE_12000, RATE_24000: return 6'd30;
      default:   return 6'(48 / repeat_factor(r));
    endcase
  endfunction

  // User bit carried by D bit p at a valid rate, or -1 for a fill bit.
  function automatic int dbit_source(input logic [3:0] r, input int p);
    logic [7:0][3:0] data_runs;
    logic [7:0][3:0] fill_runs;
    int              di;
    int              ui;
    int              res;
    if (repeat_factor(r) != 0) return p / repeat_factor(r);
    if (r == RATE_12000 || r == RATE_24000) begin
      data_runs = RUN_DATA_12000;
      fill_runs = RUN_FILL_12000;
    end else begin
      data_runs = RUN_DATA_3600;
      fill_runs = RUN_FILL_3600;
    end
    di  = 0;
    ui  = 0;
    res = -1;
    for (int s = 0; s < 8; s++) begin
      for (int k = 0; k < int'(data_runs[s]); k++) begin
        if (di == p) res = ui;
        di++;
        ui++;
      end
      di += int'(fill_runs[s]);
    end
    return res;
  endfunction

  function automatic logic [47:0] user_to_dbits(input logic [3:0] r, input logic [47:0] u);
    logic [47:0] d;
    int          src;
    for (int p = 0; p < 48; p++) begin
      src  = dbit_source(r, p);
      d[p] = (src < 0) ? 1'b1 : u[src];
    end
    return d;
  endfunction

  // D bits fill positions 1..6 of octets 1-4 and 6-9.
  function automatic int dbit_octet(input int q);
    return (q / 6 < 4) ? q / 6 + 1 : q / 6 + 2;
  endfunction

  function automatic logic [9:0][7:0] build_frame(input logic [47:0] d, input logic [5:0] s,
                                                  input logic [1:0] x, input logic [6:0] e);
    logic [9:0][7:0] f;
    f = '0;
    for (int o = 1; o < 10; o++) f[o][0] = 1'b1;
    f[1][7] = s[0];
    f[3][7] = s[1];
    f[4][7] = s[2];
    f[6][7] = s[3];
    f[8][7] = s[4];
    f[9][7] = s[5];
    f[2][7] = x[0];
    f[7][7] = x[1];
    f[5][7:1] = e;
    for (int q = 0; q < 48; q++) f[dbit_octet(q)][1 + q % 6] = d[q];
    return f;
  endfunction

  task automatic run_ra1_codec(input codec_item_t it);
    logic [9:0][7:0] f;
    logic [47:0]     d;
    logic [47:0]     u;
    logic [6:0]      e;
    int              src;
    logic            ok;
    ra1_result_t     res;
    if (it.command == vra1_pkg::CMD_ENCODE) begin
      if (model_rate >= RATES_IN_USE) return;
      f = build_frame(user_to_dbits(model_rate, it.user_bits), it.s_bits, it.x_bits,
                      {it.e_upper, ecode_of(model_rate)});
      for (int o = 0; o < 10; o++) begin
        res             = '0;
        res.tx_octet    = f[o];
        res.octet_index = 4'(o);
        res.last        = (o == 9);
        ra1_results_due.push_back(res);
      end
    end else begin
      rx_store[rx_count] = it.rx_octet;
      rx_count++;
      if (rx_count < 10) return;
      rx_count = 0;
      f = rx_store;
      for (int q = 0; q < 48; q++) d[q] = f[dbit_octet(q)][1 + q % 6];
      e  = f[5][7:1];
      ok = (model_rate < RATES_IN_USE) && (e[2:0] == ecode_of(model_rate));
      u  = '0;
      // Walking downwards lets the first copy of a repeated bit win.
      if (ok) begin
        for (int p = 47; p >= 0; p--) begin
          src = dbit_source(model_rate, p);
          if (src >= 0) u[src] = d[p];
        end
      end
      res               = '0;
      res.octet_index   = vra1_pkg::LAST_OCTET;
      res.last          = 1'b1;
      res.user_bits_out = u;
      res.user_count    = ok ? chunk_of(model_rate) : 6'd0;
      res.s_bits_out    = {f[9][7], f[8][7], f[6][7], f[4][7], f[3][7], f[1][7]};
      res.x_bits_out    = {f[7][7], f[2][7]};
      res.e_bits_out    = e;
      res.status        = ~ok;
      ra1_results_due.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] wanted);
    if (got !== wanted)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, wanted));
  endtask

  // Input driver: a new transfer is offered only once the previous one has gone.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    codec_item_t job;
    if (!rst_ni) begin
      codec_in.valid <= 1'b0;
    end else if (!codec_in.valid || codec_in.ready) begin
      if (codec_jobs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        job = codec_jobs.pop_front();
        codec_in.valid     <= 1'b1;
        codec_in.command   <= job.command;
        codec_in.user_bits <= job.user_bits;
        codec_in.s_bits    <= job.s_bits;
        codec_in.x_bits    <= job.x_bits;
        codec_in.e_upper   <= job.e_upper;
        codec_in.rx_octet  <= job.rx_octet;
      end else begin
        codec_in.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_out.ready <= 1'b0;
    end else begin
      codec_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Prediction comes first so that a same-edge result would still find its expectation.
  always @(posedge clk_i) begin : monitor
    codec_item_t seen;
    ra1_result_t want;
    if (rst_ni) begin
      if (codec_in.valid && codec_in.ready) begin
        seen.command   = vra1_pkg::cmd_e'(codec_in.command);
        seen.user_bits = codec_in.user_bits;
        seen.s_bits    = codec_in.s_bits;
        seen.x_bits    = codec_in.x_bits;
        seen.e_upper   = codec_in.e_upper;
        seen.rx_octet  = codec_in.rx_octet;
        run_ra1_codec(seen);
      end
      if (codec_out.valid && codec_out.ready) begin
        if (ra1_results_due.size() == 0) begin
          report_mismatch("result transfer with no result outstanding");
        end else begin
          want = ra1_results_due.pop_front();
          compare_field("tx_octet", 64'(codec_out.tx_octet), 64'(want.tx_octet));
          compare_field("octet_index", 64'(codec_out.octet_index), 64'(want.octet_index));
          compare_field("last", 64'(codec_out.last), 64'(want.last));
          compare_field("user_bits_out", 64'(codec_out.user_bits_out),
                        64'(want.user_bits_out));
          compare_field("user_count", 64'(codec_out.user_count), 64'(want.user_count));
          compare_field("s_bits_out", 64'(codec_out.s_bits_out), 64'(want.s_bits_out));
          compare_field("x_bits_out", 64'(codec_out.x_bits_out), 64'(want.x_bits_out));
          compare_field("e_bits_out", 64'(codec_out.e_bits_out), 64'(want.e_bits_out));
          compare_field("status", 64'(codec_out.status), 64'(want.status));
        end
      end
    end
  end

  function automatic codec_item_t random_item(input vra1_pkg::cmd_e cmd);
    codec_item_t it;
    it.command   = cmd;
    it.user_bits = rnd48();
    it.s_bits    = 6'($urandom());
    it.x_bits    = 2'($urandom());
    it.e_upper   = 4'($urandom());
    it.rx_octet  = 8'($urandom());
    return it;
  endfunction

  task automatic queue_job(input codec_item_t it);
    codec_jobs.push_back(it);
    if (it.command == vra1_pkg::CMD_RECEIVE) gen_rx_phase = (gen_rx_phase + 1) % 10;
    // An encode at an unused rate is dropped by the codec.
    if (it.command == vra1_pkg::CMD_RECEIVE || model_rate < RATES_IN_USE) items_made++;
  endtask

  task automatic queue_frame(input logic [9:0][7:0] f, input int encode_pct);
    codec_item_t it;
    for (int o = 0; o < 10; o++) begin
      if ($urandom_range(0, 99) < encode_pct) queue_job(random_item(vra1_pkg::CMD_ENCODE));
      it          = random_item(vra1_pkg::CMD_RECEIVE);
      it.rx_octet = f[o];
      queue_job(it);
    end
  endtask

  task automatic wait_until_idle();
    while (codec_jobs.size() != 0 || codec_in.valid || ra1_results_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_rate(input logic [3:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    model_rate = value;
  endtask

  initial begin : stimulus
    codec_item_t     it;
    logic [9:0][7:0] f;
    logic [47:0]     d;
    logic [2:0]      code;
    int              pick;
    int              phase_goal;

    // Directed: field extremes for encode, a frame of all ones, and a clean frame with
    // stray bits in octet 0 and in position 0.
    it = random_item(vra1_pkg::CMD_ENCODE);
    it.user_bits = '1;
    it.s_bits    = '1;
    it.x_bits    = '1;
    it.e_upper   = '1;
    queue_job(it);
    it = '0;
    it.command = vra1_pkg::CMD_ENCODE;
    queue_job(it);
    queue_frame({10{8'hFF}}, 0);
    f = build_frame(user_to_dbits(RATE_600, rnd48()), 6'($urandom()), 2'($urandom()),
                    {4'($urandom()), ECODE_600});
    f[0] = 8'hFF;
    for (int o = 1; o < 10; o++) f[o][0] = 1'b0;
    queue_frame(f, 0);
    wait_until_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_rate(phase_rate[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      phase_goal = items_made + ITEMS_PER_PHASE;
      while (items_made < phase_goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          it = random_item(vra1_pkg::CMD_ENCODE);
          case ($urandom_range(0, 9))
            0:       it.user_bits = '1;
            1:       it.user_bits = '0;
            default: ;
          endcase
          queue_job(it);
        end else if (pick < 85) begin
          // Realign to a frame boundary after any stray octets.
          while (gen_rx_phase != 0) queue_job(random_item(vra1_pkg::CMD_RECEIVE));
          if (model_rate < RATES_IN_USE) begin
            d = user_to_dbits(model_rate, rnd48());
            pick = $urandom_range(0, 99);
            if (pick < 70) code = ecode_of(model_rate);
            else if (pick < 85) code = ecode_of(model_rate) ^ 3'b100;
            else code = 3'($urandom());
          end else begin
            d    = rnd48();
            code = 3'($urandom());
          end
          f = build_frame(d, 6'($urandom()), 2'($urandom()), {4'($urandom()), code});
          if ($urandom_range(0, 1) == 1) begin
            f[0] = 8'($urandom());
            for (int o = 1; o < 10; o++) f[o][0] = 1'($urandom());
          end
          queue_frame(f, 10);
        end else begin
          queue_job(random_item(vra1_pkg::CMD_RECEIVE));
        end
      end
      wait_until_idle();
    end

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[v110_ra1_frame_codec.f]
+incdir+design
design/vra1_pkg.sv
design/vra1_if.sv
design/vra1_front.sv
design/vra1_queue.sv
design/vra1_back.sv
design/v110_ra1_frame_codec.sv
tb/tb_v110_ra1_frame_codec.sv
